@@ design/ldda_pkg.sv @@
// shared types and constants for the divide-based dda line rasterizer
package ldda_pkg;

  localparam int COORD_W        = 6;
  localparam int COLOR_W        = 32;
  localparam int COORD_BITS_DEF = 6;

  // one line segment transaction
  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0] line_color;
  } in_item_t;

  // one pixel transaction
  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } out_item_t;

  // classified line, endpoints ordered along the major axis
  typedef struct packed {
    logic               x_major;
    logic               minor_neg;
    logic [COORD_W-1:0] origin_major;
    logic [COORD_W-1:0] origin_minor;
    logic [COORD_W-1:0] delta_major;
    logic [COORD_W-1:0] delta_minor_mag;
    logic [COLOR_W-1:0] color;
  } line_desc_t;

endpackage

@@ design/ldda_front.sv @@
// front end: accepts line transactions and classifies major axis and deltas
module ldda_front #(
  parameter int COORD_BITS = ldda_pkg::COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  ldda_pkg::in_item_t     in_data,
  output logic                   desc_valid,
  output ldda_pkg::line_desc_t   desc,
  input  logic                   desc_ready
);
  import ldda_pkg::*;

  localparam int CB = COORD_BITS;

  logic [CB-1:0] sx, sy, ex, ey;
  logic [CB-1:0] adx, ady;
  logic          x_major;
  logic [CB-1:0] a_maj, a_min, b_maj, b_min;
  logic [CB-1:0] smaj, smin, emaj, emin;
  logic          minor_neg;
  line_desc_t    desc_nxt;
  line_desc_t    desc_r;
  logic          desc_valid_r, desc_valid_nxt;
  logic          accept, push;

  // coordinates taken modulo the tile size
  assign sx = in_data.start_x[CB-1:0];
  assign sy = in_data.start_y[CB-1:0];
  assign ex = in_data.end_x[CB-1:0];
  assign ey = in_data.end_y[CB-1:0];

  // classify axis and order endpoints along the major axis
  always_comb begin
    adx     = (ex >= sx) ? ex - sx : sx - ex;
    ady     = (ey >= sy) ? ey - sy : sy - ey;
    x_major = (adx >= ady);
    a_maj   = x_major ? sx : sy;
    a_min   = x_major ? sy : sx;
    b_maj   = x_major ? ex : ey;
    b_min   = x_major ? ey : ex;
    if (a_maj > b_maj) begin
      smaj = b_maj;
      smin = b_min;
      emaj = a_maj;
      emin = a_min;
    end else begin
      smaj = a_maj;
      smin = a_min;
      emaj = b_maj;
      emin = b_min;
    end
    minor_neg                = (emin < smin);
    desc_nxt.x_major         = x_major;
    desc_nxt.minor_neg       = minor_neg;
    desc_nxt.origin_major    = COORD_W'(smaj);
    desc_nxt.origin_minor    = COORD_W'(smin);
    desc_nxt.delta_major     = COORD_W'(emaj - smaj);
    desc_nxt.delta_minor_mag = minor_neg ? COORD_W'(smin - emin) : COORD_W'(emin - smin);
    desc_nxt.color           = in_data.line_color;
  end

  // one holding stage in front of the queue
  assign push   = desc_valid_r && desc_ready;
  assign busy   = desc_valid_r && !desc_ready;
  assign accept = start && !busy;

  always_comb begin
    desc_valid_nxt = desc_valid_r;
    if (accept) begin
      desc_valid_nxt = 1'b1;
    end else if (push) begin
      desc_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_valid_r <= 1'b0;
    end else begin
      desc_valid_r <= desc_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desc_r <= desc_nxt;
    end
  end

  assign desc_valid = desc_valid_r;
  assign desc       = desc_r;

endmodule

@@ design/ldda_queue.sv @@
// two-entry queue of classified lines between front and back
module ldda_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ldda_pkg::line_desc_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output ldda_pkg::line_desc_t pop_data
);
  import ldda_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  line_desc_t       entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = entry_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ design/ldda_back.sv @@
// back end: steps along the major axis, one pixel per cycle
module ldda_back #(
  parameter int COORD_BITS = ldda_pkg::COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 desc_avail,
  input  ldda_pkg::line_desc_t desc,
  output logic                 desc_pop,
  output logic                 out_valid,
  output ldda_pkg::out_item_t  out_data
);
  import ldda_pkg::*;

  localparam int CB = COORD_BITS;

  logic          active_r, active_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;
  logic          x_major_r, minor_neg_r;
  logic [CB-1:0] omaj_r, omin_r, dmaj_r, dmag_r;
  logic [COLOR_W-1:0] color_r;
  logic [CB-1:0] t_r, t_nxt;
  logic [CB-1:0] q_r, q_nxt;
  logic [CB-1:0] rem_r, rem_nxt;
  logic [CB:0]   rem_sum;
  logic [CB-1:0] major_c, minor_c;
  logic          last_c;

  // current pixel from offset t and quotient q of dmag*t/dmaj
  always_comb begin
    major_c = CB'(omaj_r + t_r);
    minor_c = minor_neg_r ? CB'(omin_r - q_r) : CB'(omin_r + q_r);
    last_c  = (t_r == dmaj_r);
  end

  assign desc_pop = desc_avail && (!active_r || last_c);

  // incremental quotient: remainder stays below dmaj since dmag <= dmaj
  always_comb begin
    rem_sum = {1'b0, rem_r} + {1'b0, dmag_r};
    t_nxt   = CB'(t_r + 1'b1);
    q_nxt   = q_r;
    rem_nxt = CB'(rem_sum);
    if (rem_sum >= {1'b0, dmaj_r}) begin
      q_nxt   = CB'(q_r + 1'b1);
      rem_nxt = CB'(rem_sum - {1'b0, dmaj_r});
    end
    if (desc_pop) begin
      t_nxt   = '0;
      q_nxt   = '0;
      rem_nxt = '0;
    end
  end

  // sequencing and registered pixel output
  always_comb begin
    active_nxt    = active_r;
    if (desc_pop) begin
      active_nxt = 1'b1;
    end else if (active_r && last_c) begin
      active_nxt = 1'b0;
    end
    out_valid_nxt            = active_r;
    out_data_nxt.pixel_x     = x_major_r ? COORD_W'(major_c) : COORD_W'(minor_c);
    out_data_nxt.pixel_y     = x_major_r ? COORD_W'(minor_c) : COORD_W'(major_c);
    out_data_nxt.pixel_color = color_r;
    out_data_nxt.last_pixel  = last_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // line payload and step counters
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    t_r        <= t_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    if (desc_pop) begin
      x_major_r   <= desc.x_major;
      minor_neg_r <= desc.minor_neg;
      omaj_r      <= desc.origin_major[CB-1:0];
      omin_r      <= desc.origin_minor[CB-1:0];
      dmaj_r      <= desc.delta_major[CB-1:0];
      dmag_r      <= desc.delta_minor_mag[CB-1:0];
      color_r     <= desc.color;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/line_rasterizer_divide_dda.sv @@
// top level of the divide-based dda line rasterizer
//
// input channel: a line transaction (two endpoints, colour) is taken at a
// rising edge where start is high and busy is low. busy rises only when the
// holding stage and the two-entry line queue are all full.
// output channel: one pixel transaction per cycle while out_valid is high,
// pixels in ascending order of the major coordinate, last_pixel on the
// final one. the receiver cannot stall; every strobed pixel is taken.
// path: when the back end is idle, the first pixel of a line passes the holding
// stage, the queue, the back end's line registers and the output register.
// throughput: a line of major length d gives d + 1 pixels, 1 to 64; the back
// end emits one pixel per cycle and loads the next queued line in the cycle
// of the last pixel, so queued lines stream without gaps. that step loop, one
// add and compare per pixel for the minor quotient, sets the rate.
// reset: synchronous, active low; clears the queue, any line in progress and
// the output strobe. busy is low right after reset.
module line_rasterizer_divide_dda #(
  parameter int COORD_BITS = ldda_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ldda_pkg::in_item_t  in_data,
  output logic                out_valid,
  output ldda_pkg::out_item_t out_data
);
  import ldda_pkg::*;

  logic       front_valid, queue_full, queue_avail, queue_pop;
  line_desc_t front_desc, queue_desc;

  // classify incoming lines
  ldda_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .desc_valid (front_valid),
    .desc       (front_desc),
    .desc_ready (!queue_full)
  );

  // decouple front and back
  ldda_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_valid),
    .push_data (front_desc),
    .full      (queue_full),
    .pop       (queue_pop),
    .not_empty (queue_avail),
    .pop_data  (queue_desc)
  );

  // walk each line
  ldda_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_avail (queue_avail),
    .desc       (queue_desc),
    .desc_pop   (queue_pop),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

@@ design/ldda_checker.sv @@
// port-level checker for the line rasterizer, bound to the top level
module ldda_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input ldda_pkg::in_item_t  in_data,
  input logic                out_valid,
  input ldda_pkg::out_item_t out_data
);
  import ldda_pkg::*;

  // nothing comes out or stalls the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !busy)
    else $error("output or busy active after reset");

  // pixels of one line follow each other without gaps
  a_line_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_pixel |=> out_valid)
    else $error("gap inside a line");

  // colour holds for the whole line
  a_color_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_pixel |=> $stable(out_data.pixel_color))
    else $error("colour changed inside a line");

  // the major coordinate steps by one per pixel
  a_major_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_pixel |=>
      (out_data.pixel_x == COORD_W'($past(out_data.pixel_x) + 1'b1)) ||
      (out_data.pixel_y == COORD_W'($past(out_data.pixel_y) + 1'b1)))
    else $error("major coordinate did not advance by one");

endmodule

bind line_rasterizer_divide_dda ldda_checker u_ldda_checker (.*);

@@ sim/line_rasterizer_divide_dda_test.sv @@
// self-checking testbench for the divide-based dda line rasterizer
`timescale 1ns / 100ps

module line_rasterizer_divide_dda_test;
  import ldda_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_LINES = 430;
  localparam int SETTLE_CYCLES = 16;

  // line kinds for the random part
  typedef enum int {
    LINE_ANY,
    LINE_SHORT,
    LINE_FLAT,
    LINE_STEEP_AXIS,
    LINE_DIAG,
    LINE_POINT
  } line_kind_t;

  typedef struct {
    in_item_t  seg;
    bit        known;
    out_item_t px;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  out_item_t pending_pixels[$];
  stim_row_t directed_rows[$];
  int        fault_count;
  int        idle_cycles;
  bit        burst_mode;

  line_rasterizer_divide_dda dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic in_item_t mk_seg(int sx, int sy, int ex, int ey, logic [31:0] color);
    in_item_t s;
    s.start_x    = COORD_W'(sx);
    s.start_y    = COORD_W'(sy);
    s.end_x      = COORD_W'(ex);
    s.end_y      = COORD_W'(ey);
    s.line_color = color;
    return s;
  endfunction

  function automatic out_item_t mk_px(int x, int y, logic [31:0] color, bit last);
    out_item_t p;
    p.pixel_x     = COORD_W'(x);
    p.pixel_y     = COORD_W'(y);
    p.pixel_color = color;
    p.last_pixel  = last;
    return p;
  endfunction

  // expected pixels of one line, walked along the major axis
  function automatic void plot_line(in_item_t seg);
    int        sx, sy, ex, ey;
    int        smaj, smin, emaj, emin, tmp;
    int        dmaj, dmin, minor, ax, ay;
    bit        xmaj;
    out_item_t px;
    sx = int'(seg.start_x);
    sy = int'(seg.start_y);
    ex = int'(seg.end_x);
    ey = int'(seg.end_y);
    ax = (ex >= sx) ? ex - sx : sx - ex;
    ay = (ey >= sy) ? ey - sy : sy - ey;
    xmaj = (ax >= ay);
    smaj = xmaj ? sx : sy;
    smin = xmaj ? sy : sx;
    emaj = xmaj ? ex : ey;
    emin = xmaj ? ey : ex;
    // put the endpoints in ascending major order
    if (smaj > emaj) begin
      tmp = smaj; smaj = emaj; emaj = tmp;
      tmp = smin; smin = emin; emin = tmp;
    end
    dmaj = emaj - smaj;
    dmin = emin - smin;
    for (int t = 0; t <= dmaj; t++) begin
      // signed int division truncates toward zero
      minor = smin + ((dmaj == 0) ? 0 : (dmin * t) / dmaj);
      px.pixel_x     = COORD_W'(xmaj ? smaj + t : minor);
      px.pixel_y     = COORD_W'(xmaj ? minor : smaj + t);
      px.pixel_color = seg.line_color;
      px.last_pixel  = (t == dmaj);
      pending_pixels.push_back(px);
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
    fault_count++;
  endtask

  // offer one line and wait for the transaction to be taken
  task automatic send_line(stim_row_t row);
    start   <= 1'b1;
    in_data <= row.seg;
    do @(posedge clk); while (busy);
    if (row.known) pending_pixels.push_back(row.px);
    else plot_line(row.seg);
  endtask

  // gap after a transaction; start only drops when a gap follows
  task automatic sender_gap();
    int r, gap;
    r = $urandom_range(0, 99);
    if (burst_mode) gap = 0;
    else if (r < 55) gap = $urandom_range(0, 2);
    else if (r < 90) gap = $urandom_range(3, 8);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_pixels();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : (v > 63) ? 63 : v;
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t  row;
    line_kind_t kind;
    int         sx, sy, ex, ey, len;
    int         r;
    r = $urandom_range(0, 9);
    kind = (r < 4) ? LINE_ANY : line_kind_t'(r - 3);
    if (kind > LINE_POINT) kind = LINE_ANY;
    sx = $urandom_range(0, 63);
    sy = $urandom_range(0, 63);
    ex = $urandom_range(0, 63);
    ey = $urandom_range(0, 63);
    case (kind)
      LINE_SHORT: begin
        ex = clamp_coord(sx + $urandom_range(0, 6) - 3);
        ey = clamp_coord(sy + $urandom_range(0, 6) - 3);
      end
      LINE_FLAT: begin
        ey = sy;
      end
      LINE_STEEP_AXIS: begin
        ex = sx;
      end
      LINE_DIAG: begin
        len = (ex >= sx) ? ex - sx : sx - ex;
        sy = $urandom_range(0, 63 - len);
        ey = sy + len;
        if ($urandom_range(0, 1)) begin
          r = sy; sy = ey; ey = r;
        end
      end
      LINE_POINT: begin
        ex = sx;
        ey = sy;
      end
      default: ;
    endcase
    row.seg   = mk_seg(sx, sy, ex, ey, $urandom);
    row.known = 1'b0;
    row.px    = '0;
    return row;
  endfunction

  // pixel checker, output sampled at the edge that takes it
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel with nothing pending",
                        32'({out_data.pixel_x, out_data.pixel_y}), '0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.pixel_x !== want.pixel_x)
          report_mismatch("pixel_x", 32'(out_data.pixel_x), 32'(want.pixel_x));
        if (out_data.pixel_y !== want.pixel_y)
          report_mismatch("pixel_y", 32'(out_data.pixel_y), 32'(want.pixel_y));
        if (out_data.pixel_color !== want.pixel_color)
          report_mismatch("pixel_color", out_data.pixel_color, want.pixel_color);
        if (out_data.last_pixel !== want.last_pixel)
          report_mismatch("last_pixel", 32'(out_data.last_pixel), 32'(want.last_pixel));
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] watchdog expired with %0d pixels pending", $time, pending_pixels.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  // directed lines: points are typed in, the rest go through the predictor
  initial begin
    directed_rows.push_back('{mk_seg(0, 0, 0, 0, 32'h0), 1'b1,
                              mk_px(0, 0, 32'h0, 1'b1)});
    directed_rows.push_back('{mk_seg(63, 63, 63, 63, 32'hffff_ffff), 1'b1,
                              mk_px(63, 63, 32'hffff_ffff, 1'b1)});
    directed_rows.push_back('{mk_seg(21, 42, 21, 42, 32'h5a5a_5a5a), 1'b1,
                              mk_px(21, 42, 32'h5a5a_5a5a, 1'b1)});
    directed_rows.push_back('{mk_seg(0, 63, 63, 63, 32'hffff_ffff), 1'b0, '0});
    directed_rows.push_back('{mk_seg(63, 0, 0, 0, 32'h0), 1'b0, '0});
    directed_rows.push_back('{mk_seg(0, 0, 0, 63, 32'h1234_5678), 1'b0, '0});
    directed_rows.push_back('{mk_seg(63, 63, 63, 0, 32'h8765_4321), 1'b0, '0});
    directed_rows.push_back('{mk_seg(0, 0, 63, 63, 32'haaaa_aaaa), 1'b0, '0});
    directed_rows.push_back('{mk_seg(0, 63, 63, 0, 32'h5555_5555), 1'b0, '0});
    directed_rows.push_back('{mk_seg(63, 0, 0, 63, 32'hdead_beef), 1'b0, '0});
    directed_rows.push_back('{mk_seg(0, 5, 7, 0, 32'h0f0f_0f0f), 1'b0, '0});
    directed_rows.push_back('{mk_seg(7, 0, 0, 5, 32'hf0f0_f0f0), 1'b0, '0});
    directed_rows.push_back('{mk_seg(10, 0, 13, 63, 32'h0000_0001), 1'b0, '0});
    directed_rows.push_back('{mk_seg(50, 2, 40, 60, 32'h8000_0000), 1'b0, '0});
    directed_rows.push_back('{mk_seg(5, 5, 6, 5, 32'hcafe_f00d), 1'b0, '0});
    directed_rows.push_back('{mk_seg(5, 5, 5, 4, 32'h3c3c_3c3c), 1'b0, '0});
    directed_rows.push_back('{mk_seg(0, 0, 62, 63, 32'h7fff_ffff), 1'b0, '0});
    directed_rows.push_back('{mk_seg(1, 2, 63, 62, 32'hfffe_0001), 1'b0, '0});
    directed_rows.push_back('{mk_seg(42, 21, 21, 42, 32'h2a2a_1515), 1'b0, '0});
  end

  // main sequence
  initial begin
    stim_row_t row;
    burst_mode  = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    foreach (directed_rows[i]) begin
      send_line(directed_rows[i]);
      sender_gap();
    end
    drain_pixels();

    // random part, with bursts of back-to-back lines and one full drain midway
    for (int n = 0; n < RANDOM_LINES; n++) begin
      if ($urandom_range(0, 29) == 0) burst_mode = !burst_mode;
      row = random_row();
      send_line(row);
      if (n == RANDOM_LINES / 2) drain_pixels();
      else sender_gap();
    end
    start <= 1'b0;

    // let every pending pixel arrive, then watch for strays
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ldda_pkg.sv
design/ldda_front.sv
design/ldda_queue.sv
design/ldda_back.sv
design/line_rasterizer_divide_dda.sv
design/ldda_checker.sv
sim/line_rasterizer_divide_dda_test.sv
